// File: rtl/multi_queue_shared_buffer_defines.svh
// ------------------------------------------------------------------------
// Multi-queue shared buffer: assertion macros
// Shared shorthand for the concurrent checks in the RTL files. Every macro
// samples on clk and stays quiet while arst_n is low.
// ------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQSB_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mqsb_pkg.sv
// ------------------------------------------------------------------------
// Multi-queue shared buffer package
// Sizes, codes, shared types and small helper functions for the block.
// ------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

	localparam int MEM_DEPTH   = 32;
	localparam int QUEUE_LIMIT = 4;
	localparam int DATA_WIDTH  = 32;

	// Field widths of the stream items and the register.
	localparam int CMD_W  = 1;
	localparam int QN_W   = 2;
	localparam int PD_W   = 32;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 3;

	localparam int S_FIELDS_W = CMD_W + QN_W + PD_W;
	localparam int M_FIELDS_W = ST_W + PD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int TD_CMD_LSB  = 0;
	localparam int TD_QN_LSB   = TD_CMD_LSB + CMD_W;
	localparam int TD_DATA_LSB = TD_QN_LSB + QN_W;

	// Only the low bits of an item that can ever come back out are stored.
	localparam int STORE_W = (DATA_WIDTH < PD_W) ? DATA_WIDTH : PD_W;

	localparam int AW    = $clog2(MEM_DEPTH);
	localparam int OFF_W = AW;
	localparam int SEG_W = $clog2(MEM_DEPTH + 1);

	// Queues that a two-bit queue number can reach.
	localparam int NUM_Q = (QUEUE_LIMIT < (1 << QN_W)) ? QUEUE_LIMIT : (1 << QN_W);
	localparam int QI_W  = (NUM_Q > 1) ? $clog2(NUM_Q) : 1;

	localparam int OPQ_DEPTH = 2;

	// Segment size for every value a three-bit count can take.
	localparam int SEG_BY_COUNT [8] = '{
		0,
		MEM_DEPTH / 1,
		MEM_DEPTH / 2,
		MEM_DEPTH / 3,
		MEM_DEPTH / 4,
		MEM_DEPTH / 5,
		MEM_DEPTH / 6,
		MEM_DEPTH / 7
	};

	// Configuration port.
	localparam int APB_DW     = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_ADDR_W = CFG_IDX_W + 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_COUNT = CFG_IDX_W'(0);
	localparam logic [CNT_W-1:0]     QCOUNT_RESET    = CNT_W'(4);

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BADQ  = 2'd3
	} status_t;

	// One classified access on its way to the memory.
	typedef struct packed {
		logic                wr;
		logic                rd;
		status_t             status;
		logic [AW-1:0]       addr;
		logic [STORE_W-1:0]  data;
	} op_t;

	// Queue layout as set by the register, plus the empty-all strobe.
	typedef struct packed {
		logic              clear;
		logic [CNT_W-1:0]  count;
		logic [SEG_W-1:0]  seg;
	} cfg_t;

	// A count of zero acts as one and a count above the limit as the limit.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c == '0)
			r = CNT_W'(1);
		else if (int'(c) > QUEUE_LIMIT)
			r = CNT_W'(QUEUE_LIMIT);
		return r;
	endfunction

	// Segment size for each possible count, taken from constants.
	function automatic logic [SEG_W-1:0] seg_size(input logic [CNT_W-1:0] c);
		logic [SEG_W-1:0] s;
		s = '0;
		if (int'(c) <= QUEUE_LIMIT)
			s = SEG_W'(SEG_BY_COUNT[c]);
		return s;
	endfunction

endpackage

`default_nettype wire

// File: rtl/multi_queue_shared_buffer.sv
// Several circular FIFO queues share one item memory, split into equal
// segments by the queue_count register (count 0 acts as 1). Each stream
// transaction pushes or pops one queue and yields exactly one result with a
// status and, on a good pop, the item. The block sustains one transaction
// per clock while the sink is ready; a result passes through the offset
// check stage in the front end, the two-entry operation queue and the
// registered memory read on its way to the output. Writing queue_count
// empties all queues; there is no clearing pass after reset.
// ------------------------------------------------------------------------
// Multi-queue shared buffer
// Top level: configuration register port, front end, operation queue and
// memory side.
// ------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mqsb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mqsb_pkg::APB_DW-1:0]     pwdata,
	output logic [mqsb_pkg::APB_DW-1:0]     prdata,
	output logic                            pready,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// Fields from bit 0 up: command, queue_number, push_data.
	input  logic [mqsb_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// Fields from bit 0 up: status, pop_data.
	output logic [mqsb_pkg::M_TDATA_W-1:0]  m_tdata
);

	import mqsb_pkg::*;

	logic [CNT_W-1:0]      queue_count_q;
	logic [CNT_W-1:0]      count_eff_q;
	logic [SEG_W-1:0]      seg_q;
	logic [CFG_IDX_W-1:0]  reg_idx;
	logic                  cfg_wr;
	cfg_t                  cfg;
	logic                  op_push;
	op_t                   front_op;
	logic                  op_full;
	logic                  op_pop;
	op_t                   back_op;
	logic                  op_valid;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready && reg_idx == REG_QUEUE_COUNT;
	assign prdata  = (reg_idx == REG_QUEUE_COUNT) ? APB_DW'(queue_count_q) : '0;

	// The effective count and the segment size are kept ready beside the raw
	// register value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_count_q <= QCOUNT_RESET;
			count_eff_q   <= eff_count(QCOUNT_RESET);
			seg_q         <= seg_size(eff_count(QCOUNT_RESET));
		end else if (cfg_wr) begin
			queue_count_q <= pwdata[CNT_W-1:0];
			count_eff_q   <= eff_count(pwdata[CNT_W-1:0]);
			seg_q         <= seg_size(eff_count(pwdata[CNT_W-1:0]));
		end
	end

	assign cfg.clear = cfg_wr;
	assign cfg.count = count_eff_q;
	assign cfg.seg   = seg_q;

	mqsb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.op_push  (op_push),
		.op       (front_op),
		.op_full  (op_full)
	);

	mqsb_op_fifo u_op_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.push_op (front_op),
		.full    (op_full),
		.pop     (op_pop),
		.pop_op  (back_op),
		.valid   (op_valid)
	);

	mqsb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (back_op),
		.op_pop   (op_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

// File: rtl/mqsb_ram.sv
// ------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read data output.
// ------------------------------------------------------------------------
`default_nettype none

module mqsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/mqsb_front.sv
// ------------------------------------------------------------------------
// Multi-queue shared buffer: front end
// Registers each incoming transaction, checks it against the head and tail
// offsets of its queue, updates those offsets and hands a memory operation
// with its status to the operation queue.
// ------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mqsb_pkg::cfg_t                 cfg,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: command, queue_number, push_data.
	input  logic [mqsb_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           op_push,
	output mqsb_pkg::op_t                  op,
	input  logic                           op_full
);

	import mqsb_pkg::*;

	logic                        valid_s1;
	logic                        cmd_s1;
	logic [QN_W-1:0]             qn_s1;
	logic [STORE_W-1:0]          data_s1;

	logic [OFF_W-1:0]            head_q [NUM_Q];
	logic [OFF_W-1:0]            tail_q [NUM_Q];

	logic [QI_W-1:0]             qi;
	logic                        bad;
	logic                        seg_zero;
	logic [OFF_W-1:0]            head;
	logic [OFF_W-1:0]            tail;
	logic [OFF_W-1:0]            nh;
	logic [OFF_W-1:0]            nt;
	logic [QN_W+SEG_W-1:0]       base;
	status_t                     status;
	logic                        ok;

	function automatic logic [OFF_W-1:0] next_off(input logic [OFF_W-1:0] off,
			input logic [SEG_W-1:0] seg);
		logic [SEG_W-1:0] n;
		n = SEG_W'(off) + SEG_W'(1);
		return (n >= seg) ? '0 : OFF_W'(n);
	endfunction

	assign s_tready = !valid_s1 || !op_full;
	assign op_push  = valid_s1 && !op_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (op_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tdata[TD_CMD_LSB];
			qn_s1   <= s_tdata[TD_QN_LSB +: QN_W];
			data_s1 <= s_tdata[TD_DATA_LSB +: STORE_W];
		end
	end

	assign qi       = qn_s1[QI_W-1:0];
	assign bad      = CNT_W'(qn_s1) >= cfg.count;
	assign seg_zero = cfg.seg == '0;
	assign head     = head_q[qi];
	assign tail     = tail_q[qi];
	assign nh       = next_off(head, cfg.seg);
	assign nt       = next_off(tail, cfg.seg);
	assign base     = (QN_W+SEG_W)'(qn_s1) * (QN_W+SEG_W)'(cfg.seg);

	always_comb begin
		if (bad)
			status = ST_BADQ;
		else if (cmd_s1 == CMD_PUSH)
			status = (seg_zero || nt == head) ? ST_FULL : ST_OK;
		else
			status = (seg_zero || head == tail) ? ST_EMPTY : ST_OK;
	end

	assign ok        = status == ST_OK;
	assign op.wr     = ok && cmd_s1 == CMD_PUSH;
	assign op.rd     = ok && cmd_s1 == CMD_POP;
	assign op.status = status;
	assign op.addr   = base[AW-1:0] + ((cmd_s1 == CMD_PUSH) ? nt : nh);
	assign op.data   = data_s1;

	// The offsets move as the operation is queued, so the next transaction
	// already sees them without waiting for the memory access.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_Q; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (cfg.clear) begin
			for (int i = 0; i < NUM_Q; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (op_push) begin
			if (op.wr)
				tail_q[qi] <= nt;
			if (op.rd)
				head_q[qi] <= nh;
		end
	end

	`MQSB_ASSERT(a_no_push_when_full, op_push, !op_full, "operation queued while queue is full")
	`MQSB_ASSERT_NEXT(a_tail_moves, op_push && op.wr && !cfg.clear, tail_q[$past(qi)] != $past(tail), "accepted push left the tail in place")

endmodule

`default_nettype wire

// File: rtl/mqsb_op_fifo.sv
// ------------------------------------------------------------------------
// Multi-queue shared buffer: operation queue
// A short FIFO of classified operations between the front end and the
// memory side, so either can stall without holding up the other.
// ------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_op_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mqsb_pkg::op_t  push_op,
	output logic           full,
	input  logic           pop,
	output mqsb_pkg::op_t  pop_op,
	output logic           valid
);

	import mqsb_pkg::*;

	localparam int PW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
	localparam int CW = $clog2(OPQ_DEPTH + 1);

	op_t             entry_q [OPQ_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = count_q == CW'(OPQ_DEPTH);
	assign valid   = count_q != '0;
	assign pop_op  = entry_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PW'(OPQ_DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			if (do_pop)
				rptr_q <= (rptr_q == PW'(OPQ_DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CW'(1);
		end
	end

	`MQSB_ASSERT(a_fill_bounded, 1'b1, count_q <= CW'(OPQ_DEPTH), "operation queue overfilled")

endmodule

`default_nettype wire

// File: rtl/mqsb_back.sv
// ------------------------------------------------------------------------
// Multi-queue shared buffer: memory side
// Carries out queued operations on the shared item memory and holds each
// result in an output register until the sink takes it.
// ------------------------------------------------------------------------
`default_nettype none
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_valid,
	input  mqsb_pkg::op_t                  op,
	output logic                           op_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0 up: status, pop_data.
	output logic [mqsb_pkg::M_TDATA_W-1:0] m_tdata
);

	import mqsb_pkg::*;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic                 out_rd_q;
	logic                 ram_we;
	logic                 ram_re;
	logic [STORE_W-1:0]   ram_rdata;
	logic [PD_W-1:0]      pop_data;

	// The read data register only changes on a new read, so a stalled
	// result keeps its data.
	assign op_pop = op_valid && (!out_valid_q || m_tready);
	assign ram_we = op_pop && op.wr;
	assign ram_re = op_pop && op.rd;

	mqsb_ram #(
		.WIDTH (STORE_W),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (op.addr),
		.wdata (op.data),
		.re    (ram_re),
		.raddr (op.addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			out_status_q <= op.status;
			out_rd_q     <= op.rd;
		end
	end

	assign pop_data = out_rd_q ? PD_W'(ram_rdata) : '0;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({pop_data, out_status_q});

	`MQSB_ASSERT(a_one_port_use, ram_we, !ram_re, "write and read issued together")
	`MQSB_ASSERT_NEXT(a_read_lands, ram_re, out_valid_q && out_rd_q && out_status_q == ST_OK, "memory read without a matching result")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ------------------------------------------------------------------------
// Multi-queue shared buffer testbench
// Streams push and pop transactions into the block and checks every result
// against a cycle-free predictor of the shared-memory queues. The run walks
// through every queue_count setting, including zero and values above the
// limit, with random source gaps, sink stalls and one long sink hold-off.
// ------------------------------------------------------------------------
`default_nettype none

module tb;
	import mqsb_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_GAP     = 17;
	localparam int RES_ST_LSB  = 0;
	localparam int RES_PD_LSB  = ST_W;

	typedef struct packed {
		logic             cmd;
		logic [QN_W-1:0]  qnum;
		logic [PD_W-1:0]  data;
	} access_t;

	typedef struct packed {
		status_t          status;
		logic [PD_W-1:0]  data;
	} outcome_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [CFG_ADDR_W-1:0]  paddr    = '0;
	logic [APB_DW-1:0]      pwdata   = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// Fields from bit 0 up: command, queue_number, push_data.
	logic [S_TDATA_W-1:0]   s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// Fields from bit 0 up: status, pop_data.
	logic [M_TDATA_W-1:0]   m_tdata;

	multi_queue_shared_buffer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predictor state: register copy, item memory and per-queue offsets.
	logic [CNT_W-1:0]    qcount_shadow = QCOUNT_RESET;
	logic [PD_W-1:0]     item_mem [MEM_DEPTH];
	int                  q_head [QUEUE_LIMIT];
	int                  q_tail [QUEUE_LIMIT];

	access_t             pending_access [$];
	outcome_t            expected_outcome [$];
	access_t             cur_access;
	int                  src_gap = 0;
	logic                src_fast = 1'b0;
	logic                snk_fast = 1'b0;
	int                  snk_stall = 0;
	int                  snk_next;
	logic                hold_go = 1'b0;
	logic                hold_off = 1'b0;
	int                  cycle_count = 0;
	int                  mismatch_count = 0;
	int                  fail_count = 0;
	int                  queued_total = 0;
	int                  checked_total = 0;
	int                  n_ok = 0;
	int                  n_full = 0;
	int                  n_empty = 0;
	int                  n_badq = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int active_queue_count();
		int c;
		c = int'(qcount_shadow);
		if (c == 0)
			c = 1;
		else if (c > QUEUE_LIMIT)
			c = QUEUE_LIMIT;
		return c;
	endfunction

	function automatic void clear_queues();
		for (int i = 0; i < QUEUE_LIMIT; i++) begin
			q_head[i] = 0;
			q_tail[i] = 0;
		end
	endfunction

	// Applies one access to the predictor state and returns its result.
	function automatic outcome_t predict_outcome(input access_t a);
		outcome_t r;
		int cnt;
		int seg;
		int q;
		int nxt;
		int addr;
		r.status = ST_OK;
		r.data = '0;
		cnt = active_queue_count();
		seg = MEM_DEPTH / cnt;
		q = int'(a.qnum);
		if (q >= cnt) begin
			r.status = ST_BADQ;
		end else if (a.cmd == CMD_PUSH) begin
			if (seg == 0) begin
				r.status = ST_FULL;
			end else begin
				nxt = (q_tail[q] + 1 >= seg) ? 0 : q_tail[q] + 1;
				if (nxt == q_head[q]) begin
					r.status = ST_FULL;
				end else begin
					q_tail[q] = nxt;
					addr = q * seg + nxt;
					if (addr < MEM_DEPTH)
						item_mem[addr] = a.data;
				end
			end
		end else begin
			if (seg == 0 || q_head[q] == q_tail[q]) begin
				r.status = ST_EMPTY;
			end else begin
				nxt = (q_head[q] + 1 >= seg) ? 0 : q_head[q] + 1;
				q_head[q] = nxt;
				addr = q * seg + nxt;
				if (addr < MEM_DEPTH)
					r.data = item_mem[addr];
			end
		end
		return r;
	endfunction

	// Source side: holds each transaction until accepted, then idles for
	// the gap drawn when it was loaded.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_outcome.push_back(predict_outcome(cur_access));
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap <= src_gap - 1;
				end else if (pending_access.size() != 0) begin
					cur_access <= pending_access[0];
					s_tdata <= S_TDATA_W'({pending_access[0].data,
						pending_access[0].qnum, pending_access[0].cmd});
					s_tvalid <= 1'b1;
					src_gap <= src_fast ? 0 : $urandom_range(0, MAX_GAP);
					void'(pending_access.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: checks each result and stalls after it for a drawn time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_stall <= 0;
		end else begin
			snk_next = snk_stall;
			if (m_tvalid && m_tready) begin
				checked_total <= checked_total + 1;
				if (expected_outcome.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("tb: result with nothing expected: status %0d data %h",
						m_tdata[RES_ST_LSB +: ST_W], m_tdata[RES_PD_LSB +: PD_W]);
				end else begin
					case (expected_outcome[0].status)
						ST_OK:    n_ok <= n_ok + 1;
						ST_FULL:  n_full <= n_full + 1;
						ST_EMPTY: n_empty <= n_empty + 1;
						default:  n_badq <= n_badq + 1;
					endcase
					if (m_tdata[RES_ST_LSB +: ST_W] !== expected_outcome[0].status ||
						m_tdata[RES_PD_LSB +: PD_W] !== expected_outcome[0].data) begin
						fail_count <= fail_count + 1;
						mismatch_count <= mismatch_count + 1;
						if (mismatch_count < 10)
							$display("tb: mismatch: expected status %0d data %h, got %0d %h",
								expected_outcome[0].status, expected_outcome[0].data,
								m_tdata[RES_ST_LSB +: ST_W], m_tdata[RES_PD_LSB +: PD_W]);
					end
					void'(expected_outcome.pop_front());
				end
				snk_next = snk_fast ? 0 : $urandom_range(0, MAX_GAP);
			end else if (snk_next != 0) begin
				snk_next = snk_next - 1;
			end
			snk_stall <= snk_next;
			m_tready <= (snk_next == 0) && !hold_off;
		end
	end

	// The long hold-off lets the block fill up while the source keeps going.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_access(input logic cmd, input int qnum, input logic [PD_W-1:0] data);
		access_t a;
		a.cmd = cmd;
		a.qnum = QN_W'(qnum);
		a.data = data;
		pending_access.push_back(a);
		queued_total = queued_total + 1;
	endtask

	task automatic add_random(input int count, input int push_pct);
		int live;
		live = active_queue_count();
		for (int i = 0; i < count; i++) begin
			add_access(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP,
				($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(0, live - 1),
				$urandom);
		end
	endtask

	// Waits until every queued transaction has been answered, then lets the
	// pipeline settle.
	task automatic wait_drained();
		while (checked_total != queued_total)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_queue_count(input int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * REG_QUEUE_COUNT);
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		qcount_shadow = CNT_W'(value);
		clear_queues();
	endtask

	initial begin
		int settings [8];
		clear_queues();
		settings = '{1, 0, 2, 7, 3, 5, 6, 4};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset layout: four queues of eight words, seven items each.
		add_access(CMD_PUSH, 0, 32'h7fff_ffff);
		add_access(CMD_PUSH, 0, 32'h8000_0000);
		add_access(CMD_PUSH, 3, 32'hffff_ffff);
		add_access(CMD_POP, 0, 32'h0);
		add_access(CMD_POP, 0, 32'hffff_ffff);
		add_access(CMD_POP, 0, 32'h0);
		add_access(CMD_POP, 3, 32'h0);
		for (int i = 0; i < 8; i++)
			add_access(CMD_PUSH, 1, 32'h0);
		add_access(CMD_POP, 1, 32'h0);
		wait_drained();

		// Three queues leave queue number three out of range.
		write_queue_count(3);
		add_access(CMD_PUSH, 3, 32'h1234_5678);
		add_access(CMD_POP, 3, 32'h0);
		add_access(CMD_PUSH, 2, 32'h0);
		add_access(CMD_POP, 2, 32'h0);
		wait_drained();

		foreach (settings[p]) begin
			write_queue_count(settings[p]);
			src_fast = ($urandom_range(0, 3) == 0);
			snk_fast = ($urandom_range(0, 3) == 0);
			if (p == 2) begin
				src_fast = 1'b1;
				hold_go = 1'b1;
			end
			add_random(50, 70);
			add_random(40, 30);
			wait_drained();
		end

		$display("summary: %0d results checked (ok %0d, full %0d, empty %0d, bad queue %0d)",
			n_ok + n_full + n_empty + n_badq, n_ok, n_full, n_empty, n_badq);
		$display("summary: queue counts 0 to 7 written, %0d mismatches", mismatch_count);
		if (fail_count == 0 && expected_outcome.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

// File: multi_queue_shared_buffer.f
+incdir+rtl
rtl/mqsb_pkg.sv
rtl/mqsb_ram.sv
rtl/mqsb_front.sv
rtl/mqsb_op_fifo.sv
rtl/mqsb_back.sv
rtl/multi_queue_shared_buffer.sv
tb/sv/tb.sv
